/* rtl/iau_pkg.sv */
// Shared operation and error codes of the interval arithmetic unit.
package iau_pkg;

  typedef enum logic [3:0] {
    KIND_ADD         = 4'd0,
    KIND_SUB         = 4'd1,
    KIND_MUL         = 4'd2,
    KIND_DIV         = 4'd3,
    KIND_SQRT        = 4'd4,
    KIND_SQUARE      = 4'd5,
    KIND_ISECT       = 4'd6,
    KIND_ROUND       = 4'd7,
    KIND_TEST_ISECT  = 4'd8,
    KIND_TEST_INSIDE = 4'd9
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_DIV_ZERO = 2'd1,
    ERR_ROOT_NEG = 2'd2,
    ERR_EMPTY    = 2'd3
  } err_e;

  // Four cross-product or quotient lanes, two square-root lanes.
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned NUM_ROOTS = 2;

endpackage

/* rtl/interval_arithmetic_unit.sv */
// Interval arithmetic unit: pipelined add, sub, mul, div, sqrt, square, intersect, round and tests.
// Throughput: one transaction per cycle while the master side takes each result;
// the depth is set by the restoring dividers, which resolve one quotient bit per
// pipeline stage. The default parameters give the Q16.16 format.
// Reset clears only the valid bits of the pipeline; payload registers are not reset.
module interval_arithmetic_unit import iau_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // From bit 0 up: a_lower, a_upper, b_lower, b_upper (DATA_WIDTH bits each), zero pad.
  input  logic [((4*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata_i,
  // kind (4 bits): operation code.
  input  logic [3:0] s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // From bit 0 up: res_lower, res_upper (DATA_WIDTH bits each), test_true,
  // error_code (2 bits), overflow, zero pad.
  output logic [((2*DATA_WIDTH+4+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int unsigned W      = DATA_WIDTH;
  localparam int unsigned F      = FRAC_BITS;
  // Quotient bits of one division, and digit pairs of one square root.
  localparam int unsigned NQ     = W + F;
  localparam int unsigned NP     = (W + F + 1) / 2;
  // Common magnitude width for the rounding and saturation of products and quotients.
  localparam int unsigned QW     = 2 * W + F;
  localparam int unsigned RES_W  = 2 * W + 4;
  localparam int unsigned OUT_TW = ((2 * W + 4 + 7) / 8) * 8;
  // Pipeline stage numbers. Stage 1 holds the ordered operands, stage 2 the
  // prepared lanes and simple results, and stage NSTG is the output register.
  localparam int unsigned MUL_STG = 5;
  localparam int unsigned SQ_STG  = 3 + NP;
  localparam int unsigned DIV_STG = 4 + NQ;
  localparam int unsigned NSTG    = 5 + NQ;

  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    kind_e               kind;
    logic signed [W-1:0] al;
    logic signed [W-1:0] au;
    logic signed [W-1:0] bl;
    logic signed [W-1:0] bu;
  } op_t;

  // Result bundle that travels down the whole pipeline; the multiply, root and
  // divide results are written into it at the stage where they become ready.
  typedef struct packed {
    kind_e               kind;
    logic signed [W-1:0] rl;
    logic signed [W-1:0] ru;
    logic                test;
    err_e                err;
    logic                ov;
  } item_t;

  typedef struct packed {
    logic                ov;
    logic signed [W-1:0] val;
  } fin_t;

  // Saturate a sum that carries one guard bit.
  function automatic fin_t sat_f(input logic [W:0] x);
    fin_t r;
    r.ov  = (x[W] != x[W-1]);
    r.val = x[W-1:0];
    if (r.ov) begin
      r.val = x[W] ? MINV : MAXV;
    end
    return r;
  endfunction

  // Apply the sign to a floored magnitude: inexact negative values step one
  // further down, then the result saturates to the signed range.
  function automatic fin_t finish_f(input logic neg, input logic [QW-1:0] q,
                                    input logic inexact);
    logic [QW:0] qi;
    logic [QW:0] lim;
    fin_t        r;
    qi  = {1'b0, q} + (QW+1)'(neg & inexact);
    lim = neg ? ((QW+1)'(1) << (W - 1)) : (((QW+1)'(1) << (W - 1)) - (QW+1)'(1));
    r.ov = (qi > lim);
    if (r.ov) begin
      r.val = neg ? MINV : MAXV;
    end else if (neg) begin
      r.val = -qi[W-1:0];
    end else begin
      r.val = qi[W-1:0];
    end
    return r;
  endfunction

  function automatic logic [W-1:0] mag_f(input logic signed [W-1:0] x);
    return x[W-1] ? -x : x;
  endfunction

  function automatic logic signed [W-1:0] min2_f(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [W-1:0] max2_f(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // The whole pipeline advances together; it holds only while the output
  // register is full and the master side does not take it.
  logic            adv;
  logic [NSTG:1]   vld_q;

  op_t             op_d, op_q;
  item_t           simple_d;
  item_t           pipe_d [2:NSTG-1];
  item_t           pipe_q [2:NSTG-1];
  item_t           out_d, out_q;

  // Multiplier lanes: operands (stage 2), products (stage 3), rounded values (stage 4).
  logic [W-1:0]          ma_d [NUM_LANES], ma_q [NUM_LANES];
  logic [W-1:0]          mb_d [NUM_LANES], mb_q [NUM_LANES];
  logic [NUM_LANES-1:0]  mneg_d, mneg_q, pneg_q;
  logic [2*W-1:0]        prod_d [NUM_LANES], prod_q [NUM_LANES];
  logic signed [W-1:0]   mval_d [NUM_LANES], mval_q [NUM_LANES];
  logic                  mov_d, mov_q;
  logic signed [W-1:0]   mul_lo, mul_hi;

  // Divider lanes: index 0 is stage 2, index s the stage after quotient bit s.
  logic [NQ-1:0]  dnq_d  [0:NQ][NUM_LANES];
  logic [NQ-1:0]  dnq_q  [0:NQ][NUM_LANES];
  logic [W-1:0]   drem_d [0:NQ][NUM_LANES];
  logic [W-1:0]   drem_q [0:NQ][NUM_LANES];
  logic [W-1:0]   dd_d   [0:NQ][NUM_LANES];
  logic [W-1:0]   dd_q   [0:NQ][NUM_LANES];
  logic           dneg_d [0:NQ][NUM_LANES];
  logic           dneg_q [0:NQ][NUM_LANES];
  logic signed [W-1:0] dval_d [NUM_LANES], dval_q [NUM_LANES];
  logic                dov_d, dov_q;
  logic signed [W-1:0] div_lo, div_hi;

  // Square-root lanes: index 0 is stage 2, index s the stage after root digit s.
  logic [2*NP-1:0] sn_d    [0:NP][NUM_ROOTS];
  logic [2*NP-1:0] sn_q    [0:NP][NUM_ROOTS];
  logic [NP+1:0]   srem_d  [0:NP][NUM_ROOTS];
  logic [NP+1:0]   srem_q  [0:NP][NUM_ROOTS];
  logic [NP-1:0]   sroot_d [0:NP][NUM_ROOTS];
  logic [NP-1:0]   sroot_q [0:NP][NUM_ROOTS];

  logic [RES_W-1:0] res_w;

  assign adv             = !vld_q[NSTG] || m_axis_tready_i;
  assign s_axis_tready_o = adv;
  assign m_axis_tvalid_o = vld_q[NSTG];

  // Stage 1: put each input interval in order.
  always_comb begin : stage1_comb
    logic signed [W-1:0] al, au, bl, bu;
    al = s_axis_tdata_i[W-1:0];
    au = s_axis_tdata_i[2*W-1:W];
    bl = s_axis_tdata_i[3*W-1:2*W];
    bu = s_axis_tdata_i[4*W-1:3*W];
    op_d.kind = kind_e'(s_axis_tuser_i);
    op_d.al   = min2_f(al, au);
    op_d.au   = max2_f(al, au);
    op_d.bl   = min2_f(bl, bu);
    op_d.bu   = max2_f(bl, bu);
  end

  // Stage 2: the simple operations finish here, and the error checks are made.
  always_comb begin : stage2_simple
    item_t               it;
    fin_t                s0, s1;
    logic signed [W-1:0] al, au, bl, bu;
    logic signed [W-1:0] lo_max, hi_min;
    logic                frac_nz;
    al      = op_q.al;
    au      = op_q.au;
    bl      = op_q.bl;
    bu      = op_q.bu;
    it      = '0;
    it.kind = op_q.kind;
    it.err  = ERR_NONE;
    s0      = '0;
    s1      = '0;
    lo_max  = max2_f(al, bl);
    hi_min  = min2_f(au, bu);
    frac_nz = |al[F-1:0];
    case (op_q.kind)
      KIND_ADD: begin
        s0    = sat_f({al[W-1], al} + {bl[W-1], bl});
        s1    = sat_f({au[W-1], au} + {bu[W-1], bu});
        it.rl = s0.val;
        it.ru = s1.val;
        it.ov = s0.ov | s1.ov;
      end
      KIND_SUB: begin
        s0    = sat_f({al[W-1], al} - {bu[W-1], bu});
        s1    = sat_f({au[W-1], au} - {bl[W-1], bl});
        it.rl = s0.val;
        it.ru = s1.val;
        it.ov = s0.ov | s1.ov;
      end
      KIND_DIV: begin
        if (bl <= 0 && bu >= 0) begin
          it.err = ERR_DIV_ZERO;
        end
      end
      KIND_SQRT: begin
        if (au <= 0) begin
          it.err = ERR_ROOT_NEG;
        end
      end
      KIND_ISECT: begin
        if (lo_max > hi_min) begin
          it.err = ERR_EMPTY;
        end else begin
          it.rl = lo_max;
          it.ru = hi_min;
        end
      end
      KIND_ROUND: begin
        // Ceiling of the lower bound can leave the range; the floor cannot.
        s0    = sat_f({al[W-1], al[W-1:F], {F{1'b0}}} + ((W+1)'(frac_nz) << F));
        it.rl = s0.val;
        it.ov = s0.ov;
        it.ru = {au[W-1:F], {F{1'b0}}};
      end
      KIND_TEST_ISECT: begin
        it.test = (lo_max <= hi_min);
      end
      KIND_TEST_INSIDE: begin
        it.test = (au <= bu) && (al >= bl);
      end
      default: begin
      end
    endcase
    simple_d = it;
  end

  // Stage 2: magnitudes and signs for the multiplier lanes.
  always_comb begin : stage2_lanes
    logic signed [W-1:0] xa [NUM_LANES];
    logic signed [W-1:0] xb [NUM_LANES];
    logic                sq;
    sq    = (op_q.kind == KIND_SQUARE);
    xa[0] = op_q.al;
    xa[1] = op_q.al;
    xa[2] = op_q.au;
    xa[3] = op_q.au;
    xb[0] = sq ? op_q.al : op_q.bl;
    xb[1] = sq ? op_q.al : op_q.bu;
    xb[2] = sq ? op_q.au : op_q.bl;
    xb[3] = sq ? op_q.au : op_q.bu;
    for (int j = 0; j < NUM_LANES; j++) begin
      ma_d[j]   = mag_f(xa[j]);
      mb_d[j]   = mag_f(xb[j]);
      mneg_d[j] = xa[j][W-1] ^ xb[j][W-1];
    end
  end

  // Multiplier: product at stage 3, floor and saturation at stage 4.
  always_comb begin : mul_lanes
    fin_t fr;
    mov_d = 1'b0;
    for (int j = 0; j < NUM_LANES; j++) begin
      prod_d[j] = (2*W)'(ma_q[j]) * (2*W)'(mb_q[j]);
      fr        = finish_f(pneg_q[j], QW'(prod_q[j] >> F), |prod_q[j][F-1:0]);
      mval_d[j] = fr.val;
      mov_d     = mov_d | fr.ov;
    end
    mul_lo = min2_f(min2_f(mval_q[0], mval_q[1]), min2_f(mval_q[2], mval_q[3]));
    mul_hi = max2_f(max2_f(mval_q[0], mval_q[1]), max2_f(mval_q[2], mval_q[3]));
  end

  // Restoring division, one quotient bit per stage. Stage 2 loads the scaled
  // numerator magnitudes; the numerator then shifts out of the top of dnq
  // while the quotient bits shift in at the bottom.
  always_comb begin : div_steps
    logic signed [W-1:0] na [NUM_LANES];
    logic signed [W-1:0] nb [NUM_LANES];
    logic [W:0]          t;
    logic                ge;
    fin_t                fr;
    na[0] = op_q.al;
    na[1] = op_q.au;
    na[2] = op_q.al;
    na[3] = op_q.au;
    nb[0] = op_q.bl;
    nb[1] = op_q.bl;
    nb[2] = op_q.bu;
    nb[3] = op_q.bu;
    for (int j = 0; j < NUM_LANES; j++) begin
      dnq_d[0][j]  = {mag_f(na[j]), {F{1'b0}}};
      drem_d[0][j] = '0;
      dd_d[0][j]   = mag_f(nb[j]);
      dneg_d[0][j] = na[j][W-1] ^ nb[j][W-1];
    end
    for (int s = 1; s <= NQ; s++) begin
      for (int j = 0; j < NUM_LANES; j++) begin
        t            = {drem_q[s-1][j], dnq_q[s-1][j][NQ-1]};
        ge           = (t >= {1'b0, dd_q[s-1][j]});
        drem_d[s][j] = ge ? W'(t - {1'b0, dd_q[s-1][j]}) : t[W-1:0];
        dnq_d[s][j]  = {dnq_q[s-1][j][NQ-2:0], ge};
        dd_d[s][j]   = dd_q[s-1][j];
        dneg_d[s][j] = dneg_q[s-1][j];
      end
    end
    dov_d = 1'b0;
    for (int j = 0; j < NUM_LANES; j++) begin
      fr        = finish_f(dneg_q[NQ][j], QW'(dnq_q[NQ][j]), drem_q[NQ][j] != '0);
      dval_d[j] = fr.val;
      dov_d     = dov_d | fr.ov;
    end
    div_lo = min2_f(min2_f(dval_q[0], dval_q[1]), min2_f(dval_q[2], dval_q[3]));
    div_hi = max2_f(max2_f(dval_q[0], dval_q[1]), max2_f(dval_q[2], dval_q[3]));
  end

  // Digit-by-digit square root, one root bit per stage.
  always_comb begin : sqrt_steps
    logic signed [W-1:0] rad [NUM_ROOTS];
    logic [NP+3:0]       t;
    logic [NP+3:0]       trial;
    logic                ge;
    // A lower bound that is not positive has root zero, as does a zero radicand.
    rad[0] = (op_q.al > 0) ? op_q.al : '0;
    rad[1] = (op_q.au > 0) ? op_q.au : '0;
    for (int j = 0; j < NUM_ROOTS; j++) begin
      sn_d[0][j]    = (2*NP)'({rad[j], {F{1'b0}}});
      srem_d[0][j]  = '0;
      sroot_d[0][j] = '0;
    end
    for (int s = 1; s <= NP; s++) begin
      for (int j = 0; j < NUM_ROOTS; j++) begin
        t             = {srem_q[s-1][j], sn_q[s-1][j][2*NP-1:2*NP-2]};
        trial         = (NP+4)'({sroot_q[s-1][j], 2'b01});
        ge            = (t >= trial);
        srem_d[s][j]  = ge ? (NP+2)'(t - trial) : (NP+2)'(t);
        sroot_d[s][j] = (NP)'({sroot_q[s-1][j], ge});
        sn_d[s][j]    = sn_q[s-1][j] << 2;
      end
    end
  end

  // Result bundle: pass down, and fill in the lane results at their stages.
  always_comb begin : pipe_stages
    pipe_d[2] = simple_d;
    for (int k = 3; k < NSTG; k++) begin
      pipe_d[k] = pipe_q[k-1];
      if (k == MUL_STG && (pipe_q[k-1].kind == KIND_MUL ||
                           pipe_q[k-1].kind == KIND_SQUARE)) begin
        pipe_d[k].rl = mul_lo;
        pipe_d[k].ru = mul_hi;
        pipe_d[k].ov = mov_q;
      end
      if (k == SQ_STG && pipe_q[k-1].kind == KIND_SQRT &&
          pipe_q[k-1].err == ERR_NONE) begin
        pipe_d[k].rl = W'(sroot_q[NP][0]);
        pipe_d[k].ru = W'(sroot_q[NP][1]);
      end
      if (k == DIV_STG && pipe_q[k-1].kind == KIND_DIV &&
          pipe_q[k-1].err == ERR_NONE) begin
        pipe_d[k].rl = div_lo;
        pipe_d[k].ru = div_hi;
        pipe_d[k].ov = dov_q;
      end
    end
  end

  // Output register: a final swap puts the rounded interval in order.
  always_comb begin : out_stage
    out_d = pipe_q[NSTG-1];
    if (pipe_q[NSTG-1].rl > pipe_q[NSTG-1].ru) begin
      out_d.rl = pipe_q[NSTG-1].ru;
      out_d.ru = pipe_q[NSTG-1].rl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-1:1], s_axis_tvalid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_q   <= op_d;
      out_q  <= out_d;
      mneg_q <= mneg_d;
      pneg_q <= mneg_q;
      mov_q  <= mov_d;
      dov_q  <= dov_d;
      for (int k = 2; k < NSTG; k++) begin
        pipe_q[k] <= pipe_d[k];
      end
      for (int j = 0; j < NUM_LANES; j++) begin
        ma_q[j]   <= ma_d[j];
        mb_q[j]   <= mb_d[j];
        prod_q[j] <= prod_d[j];
        mval_q[j] <= mval_d[j];
        dval_q[j] <= dval_d[j];
        for (int s = 0; s <= NQ; s++) begin
          dnq_q[s][j]  <= dnq_d[s][j];
          drem_q[s][j] <= drem_d[s][j];
          dd_q[s][j]   <= dd_d[s][j];
          dneg_q[s][j] <= dneg_d[s][j];
        end
      end
      for (int j = 0; j < NUM_ROOTS; j++) begin
        for (int s = 0; s <= NP; s++) begin
          sn_q[s][j]    <= sn_d[s][j];
          srem_q[s][j]  <= srem_d[s][j];
          sroot_q[s][j] <= sroot_d[s][j];
        end
      end
    end
  end

  assign res_w          = {out_q.ov, out_q.err, out_q.test, out_q.ru, out_q.rl};
  assign m_axis_tdata_o = OUT_TW'(res_w);

  // A held result must hold the whole pipeline, or a transaction would be lost.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while the output register is stalled");

  // Every delivered interval is in order.
  a_ordered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_q.rl <= out_q.ru))
    else $error("result interval out of order");

  // An error result carries no interval, flag or test answer.
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_q.err != ERR_NONE) |->
    (out_q.rl == '0 && out_q.ru == '0 && !out_q.ov && !out_q.test))
    else $error("error result with nonzero payload");

  // A test answer comes with an empty interval and no error.
  a_test_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && out_q.test) |->
    (out_q.rl == '0 && out_q.ru == '0 && out_q.err == ERR_NONE && !out_q.ov))
    else $error("test answer with nonzero interval");

endmodule
